/* rtl/swm_pkg.sv */
// Shared constants, types and state codes of the sliding window mean block.
package swm_pkg;

   localparam int MAX_WINDOW   = 64;
   localparam int SAMPLE_BITS  = 32;
   localparam int WINDOW_BITS  = 7;
   localparam int SLOT_BITS    = $clog2(MAX_WINDOW);
   localparam int COUNT_BITS   = $clog2(MAX_WINDOW + 1);
   localparam int SUM_BITS     = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int DIV_STEPS    = SUM_BITS;
   localparam int STEP_BITS    = $clog2(DIV_STEPS);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QLEVEL_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int RSP_BITS     = ((SAMPLE_BITS + COUNT_BITS + 7) / 8) * 8;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-3:0] REG_WINDOW_LENGTH = '0;
   localparam logic [WINDOW_BITS-1:0]   WINDOW_RESET      = WINDOW_BITS'(50);

   // sum and count handed from the window update to the divider
   typedef struct packed {
      logic signed [SUM_BITS-1:0] sum;
      logic [COUNT_BITS-1:0]      count;
   } job_type;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_READ = 3'b010,
      F_SUM  = 3'b100
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_DIV  = 3'b010,
      B_DONE = 3'b100
   } back_state_type;

endpackage

/* rtl/sliding_window_mean.sv */
// Top level of the sliding window mean: register port, front end, queue, divider.
//
// Moving average over the most recent window_length samples (1..64).
// req_*: one signed 32-bit sample per word. rsp_*: one word per sample with
// the mean (sum over held samples divided by their count, truncated toward
// zero) and the number of samples currently held.
// csr_*: APB-style port, window_length at byte address 0; write it while idle.
// A zero length acts as 1, a length above 64 as 64.
// From sample accept to rsp_tvalid a word passes the front end (store read,
// sum update), then the queue, then the divider (38 quotient bits plus the
// output load).
// The word rate is set by the bit-serial divider, which resolves one quotient
// bit of the 38-bit sum per cycle.
// The front end takes a new word after pushing the last into the two-entry queue.
// Reset (synchronous) empties the window, zeroes the sum and restores the
// length to 50; the sample store itself is not cleared.
// A stalled receiver holds the result in the output register; the divider
// still finishes the next word and the front end keeps filling the queue.
module sliding_window_mean import swm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [SAMPLE_BITS-1:0]   req_tdata,    // [31:0] sample
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_BITS-1:0]      rsp_tdata,    // [31:0] mean, [38:32] samples_held
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [WINDOW_BITS-1:0] window_ff;
   logic [COUNT_BITS-1:0]  eff_length;
   logic                   reg_hit;
   logic                   push, pop, queue_full, queue_empty;
   job_type                push_job, pop_job;

   // register decode on word address
   assign csr_pready = 1'b1;
   assign reg_hit    = (csr_paddr[CSR_ADDR_BITS-1:2] == REG_WINDOW_LENGTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && reg_hit) begin
         window_ff <= csr_pwdata[WINDOW_BITS-1:0];
      end
   end

   assign csr_prdata = reg_hit ? CSR_DATA_BITS'(window_ff) : '0;

   // clamp the programmed length into 1..MAX_WINDOW
   always_comb begin
      if (window_ff == '0) begin
         eff_length = COUNT_BITS'(1);
      end else if (32'(window_ff) > MAX_WINDOW) begin
         eff_length = COUNT_BITS'(MAX_WINDOW);
      end else begin
         eff_length = COUNT_BITS'(window_ff);
      end
   end

   swm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .eff_length (eff_length),
      .push       (push),
      .push_job   (push_job),
      .queue_full (queue_full)
   );

   swm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   swm_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .pop_job    (pop_job),
      .empty      (queue_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* rtl/swm_front.sv */
// Front end: accepts samples, updates the ring store and the running sum.
module swm_front import swm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [SAMPLE_BITS-1:0] req_tdata,     // [31:0] sample
   input  logic [COUNT_BITS-1:0]  eff_length,
   output logic                   push,
   output job_type                push_job,
   input  logic                   queue_full
);

   front_state_type              state_ff, state_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] old_ff;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SLOT_BITS-1:0]          slot_ff;
   logic [SLOT_BITS-1:0]          rd_addr_ff;
   logic [COUNT_BITS-1:0]         fill_ff;
   logic                          evict_ff;
   logic [SLOT_BITS-1:0]          oldest;
   logic                          accept;

   logic signed [SAMPLE_BITS-1:0] store_mem [MAX_WINDOW];

   assign req_tready = (state_ff == F_IDLE);
   assign accept     = req_tvalid && req_tready;

   // oldest sample sits fill_ff slots behind the write slot
   always_comb begin
      if (COUNT_BITS'(slot_ff) >= fill_ff) begin
         oldest = SLOT_BITS'(COUNT_BITS'(slot_ff) - fill_ff);
      end else begin
         oldest = SLOT_BITS'(COUNT_BITS'(slot_ff) + COUNT_BITS'(MAX_WINDOW) - fill_ff);
      end
   end

   always_comb begin
      sum_in = sum_ff + SUM_BITS'(sample_ff);
      if (evict_ff) begin
         sum_in = sum_in - SUM_BITS'(old_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: if (accept) state_in = F_READ;
         F_READ: state_in = F_SUM;
         F_SUM:  if (!queue_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   assign push           = (state_ff == F_SUM) && !queue_full;
   assign push_job.sum   = sum_in;
   assign push_job.count = fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         slot_ff  <= '0;
         fill_ff  <= '0;
         sum_ff   <= '0;
         evict_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            evict_ff <= (fill_ff >= eff_length);
            if (fill_ff < eff_length) begin
               fill_ff <= fill_ff + COUNT_BITS'(1);
            end
         end
         if (state_ff == F_READ) begin
            if (slot_ff == SLOT_BITS'(MAX_WINDOW - 1)) begin
               slot_ff <= '0;
            end else begin
               slot_ff <= slot_ff + SLOT_BITS'(1);
            end
         end
         if (push) begin
            sum_ff <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff  <= req_tdata;
         rd_addr_ff <= oldest;
      end
   end

   // read-first store: with 64 samples held the evicted slot is the one written
   always_ff @(posedge clock) begin
      if (state_ff == F_READ) begin
         old_ff             <= store_mem[rd_addr_ff];
         store_mem[slot_ff] <= sample_ff;
      end
   end

endmodule

/* rtl/swm_queue.sv */
// Short job queue between the window update and the divider.
module swm_queue import swm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   job_type                q_mem [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QLEVEL_BITS-1:0] level_ff;

   assign full    = (level_ff == QLEVEL_BITS'(QUEUE_DEPTH));
   assign empty   = (level_ff == '0);
   assign pop_job = q_mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                         : wr_ptr_ff + QPTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                         : rd_ptr_ff + QPTR_BITS'(1);
         end
         if (push && !pop) begin
            level_ff <= level_ff + QLEVEL_BITS'(1);
         end else if (pop && !push) begin
            level_ff <= level_ff - QLEVEL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* rtl/swm_divider.sv */
// Back end: one bit per cycle signed division of the sum by the count.
module swm_divider import swm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  job_type             pop_job,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata      // [31:0] mean, [38:32] samples_held
);

   back_state_type         state_ff, state_in;
   logic [SUM_BITS-1:0]    quo_ff, quo_in;
   logic [COUNT_BITS-1:0]  rem_ff, rem_in;
   logic [COUNT_BITS-1:0]  div_ff;
   logic [STEP_BITS-1:0]   step_ff;
   logic                   neg_ff;
   logic                   valid_ff;
   logic [SAMPLE_BITS-1:0] mean_ff;
   logic [COUNT_BITS-1:0]  held_ff;
   logic [COUNT_BITS:0]    trial;
   logic                   ge;
   logic                   load;
   logic [SAMPLE_BITS-1:0] quo_low;

   assign pop  = (state_ff == B_IDLE) && !empty;
   assign load = (state_ff == B_DONE) && (!valid_ff || rsp_tready);

   // restoring step: remainder stays below the divisor
   always_comb begin
      trial  = {rem_ff, quo_ff[SUM_BITS-1]};
      ge     = (trial >= {1'b0, div_ff});
      rem_in = ge ? COUNT_BITS'(trial - {1'b0, div_ff}) : COUNT_BITS'(trial);
      quo_in = {quo_ff[SUM_BITS-2:0], ge};
   end

   assign quo_low = quo_ff[SAMPLE_BITS-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (pop) state_in = B_DIV;
         B_DIV:  if (step_ff == STEP_BITS'(DIV_STEPS - 1)) state_in = B_DONE;
         B_DONE: if (load) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         neg_ff  <= pop_job.sum[SUM_BITS-1];
         quo_ff  <= pop_job.sum[SUM_BITS-1] ? SUM_BITS'(-pop_job.sum) : pop_job.sum;
         div_ff  <= pop_job.count;
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (state_ff == B_DIV) begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff + STEP_BITS'(1);
      end
      // output word changes only when the output register is loaded
      if (load) begin
         mean_ff <= neg_ff ? SAMPLE_BITS'(-quo_low) : quo_low;
         held_ff <= div_ff;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_BITS'({held_ff, mean_ff});

endmodule
